// File: hw/rtl/tha_pkg.sv
package tha_pkg;

  localparam int SampleBits   = 16;
  localparam int CordicStages = 16;
  localparam int Guard        = 8;
  // CORDIC datapath width: sample scaled by 2^8, growth up to ~1.65x, sign.
  localparam int CW           = SampleBits + Guard + 3;
  localparam int AW           = 24;
  // Square root operand: (ay^2 + az^2) * 2^16.
  localparam int SqW          = 2 * SampleBits + 1 + 2 * Guard;
  localparam int RootW        = (SqW + 1) / 2;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [AW-1:0] acc_t;

  // Rounded atan(2^-i) in 1/256 centidegree.
  function automatic acc_t atan_entry(input int unsigned i);
    acc_t r;
    r = '0;
    case (i)
      0:  r = AW'(1152000);
      1:  r = AW'(680065);
      2:  r = AW'(359328);
      3:  r = AW'(182400);
      4:  r = AW'(91554);
      5:  r = AW'(45822);
      6:  r = AW'(22916);
      7:  r = AW'(11459);
      8:  r = AW'(5730);
      9:  r = AW'(2865);
      10: r = AW'(1432);
      11: r = AW'(716);
      12: r = AW'(358);
      13: r = AW'(179);
      14: r = AW'(90);
      15: r = AW'(45);
      16: r = AW'(22);
      17: r = AW'(11);
      18: r = AW'(6);
      19: r = AW'(3);
      20: r = AW'(1);
      21: r = AW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Samples carried down the square root chain.
  typedef struct packed {
    logic signed [SampleBits-1:0] ax;
    logic signed [SampleBits-1:0] ay;
    logic signed [SampleBits-1:0] az;
    logic signed [SampleBits-1:0] mx;
    logic signed [SampleBits-1:0] my;
  } smp_t;

  // One vector of a CORDIC lane.
  typedef struct packed {
    logic  zero;
    cval_t x;
    cval_t y;
    acc_t  acc;
  } vec_t;

  // Clamp and round the accumulator to centidegrees within +-18000.
  function automatic logic signed [15:0] acc_to_cdeg(input acc_t a);
    logic signed [AW:0] r;
    logic signed [AW:0] s;
    r = (AW+1)'(a) + (AW+1)'(128);
    s = r >>> 8;
    if (s > (AW+1)'(18000)) s = (AW+1)'(18000);
    if (s < -(AW+1)'(18000)) s = -(AW+1)'(18000);
    return 16'(s);
  endfunction

endpackage

// File: hw/rtl/tha_sqrt_cell.sv
// One step of a restoring integer square root: retires two operand bits.
module tha_sqrt_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [tha_pkg::SqW-1:0]  rem_i,
  input  logic [tha_pkg::SqW-1:0]  root_i,
  input  logic [tha_pkg::SqW-1:0]  bit_i,
  input  tha_pkg::smp_t            smp_i,
  output logic [tha_pkg::SqW-1:0]  rem_o,
  output logic [tha_pkg::SqW-1:0]  root_o,
  output logic [tha_pkg::SqW-1:0]  bit_o,
  output tha_pkg::smp_t            smp_o
);
  import tha_pkg::*;

  logic [SqW-1:0] trial;
  logic [SqW-1:0] rem_d, root_d;

  // Compare against root + bit and either subtract or keep.
  always_comb begin
    trial = root_i + bit_i;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + bit_i;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      bit_o  <= bit_i >> 2;
      smp_o  <= smp_i;
    end
  end

endmodule

// File: hw/rtl/tha_cordic_cell.sv
// One vectoring CORDIC iteration for a fixed shift amount.
module tha_cordic_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [4:0]    shift_i,
  input  tha_pkg::vec_t vec_i,
  output tha_pkg::vec_t vec_o
);
  import tha_pkg::*;

  cval_t dx, dy;
  acc_t  ang;
  vec_t  vec_d;

  // Rotate toward the x axis; a zero y counts as positive.
  always_comb begin
    dx    = vec_i.y >>> shift_i;
    dy    = vec_i.x >>> shift_i;
    ang   = atan_entry(32'(shift_i));
    vec_d = vec_i;
    if (!vec_i.y[CW-1]) begin
      vec_d.x   = vec_i.x + dx;
      vec_d.y   = vec_i.y - dy;
      vec_d.acc = vec_i.acc + ang;
    end else begin
      vec_d.x   = vec_i.x - dx;
      vec_d.y   = vec_i.y + dy;
      vec_d.acc = vec_i.acc - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_o <= vec_d;
  end

endmodule

// File: hw/rtl/tha_cordic_chain.sv
// Row of CORDIC cells with the quadrant pre-turn in front.
module tha_cordic_chain (
  input  logic                       clk_i,
  input  logic [tha_pkg::CordicStages:0] en_i,
  input  tha_pkg::cval_t             y_i,
  input  tha_pkg::cval_t             x_i,
  output logic signed [15:0]         cdeg_o
);
  import tha_pkg::*;

  vec_t pre_d;
  vec_t v [CordicStages+1];

  // Turn a left half plane vector by 90 degrees.
  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.x    = x_i;
    pre_d.y    = y_i;
    pre_d.acc  = '0;
    if (x_i[CW-1]) begin
      if (!y_i[CW-1]) begin
        pre_d.x   = y_i;
        pre_d.y   = -x_i;
        pre_d.acc = AW'(9000 * 256);
      end else begin
        pre_d.x   = -y_i;
        pre_d.y   = x_i;
        pre_d.acc = -AW'(9000 * 256);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) v[0] <= pre_d;
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_cell
    tha_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i[i+1]),
      .shift_i(5'(i)),
      .vec_i  (v[i]),
      .vec_o  (v[i+1])
    );
  end

  assign cdeg_o = v[CordicStages].zero ? 16'sd0 : acc_to_cdeg(v[CordicStages].acc);

endmodule

// File: hw/rtl/tilt_and_heading_angles_core.sv
// Tilt and heading angles from one accelerometer and magnetometer sample.
// Input channel s_axis: one sample per transfer, five signed axes in tdata.
// Output channel m_axis: yaw, pitch and roll in hundredths of a degree.
// The block is a chain of cells: RootW square root cells, then a pre-turn
// register and CordicStages CORDIC cells per angle, then one output register.
// Throughput is one sample per cycle; every cell advances each cycle
// unless the output is stalled and the chain stage feeding it is occupied.
// When the receiver holds m_axis_tready low, the output register keeps its
// result; the chain still moves while its last stage is empty, and
// s_axis_tready falls only once the output register is full and the chain
// stage feeding it is also occupied, so no result is lost.
// Reset clears all valid flags; the data path holds no state of meaning.
module tilt_and_heading_angles_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32],
  //        mag_x [63:48], mag_y [79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: yaw_centideg [15:0], pitch_centideg [30:16],
  //        roll_centideg [46:31], zero [47]
  output logic [47:0] m_axis_tdata
);
  import tha_pkg::*;

  localparam int Depth = RootW + CordicStages + 1;

  logic [Depth-1:0] vld_q;
  logic             adv;
  logic             out_ld;
  logic             out_vld_q;
  logic [46:0]      out_q;

  // The output register loads when it is empty or its result leaves; the
  // chain moves when the output register can take its last stage or that
  // stage is empty.
  assign out_ld        = !out_vld_q || m_axis_tready;
  assign adv           = out_ld || !vld_q[Depth-1];
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // Square root chain.
  smp_t           smp [RootW+1];
  logic [SqW-1:0] rem [RootW+1];
  logic [SqW-1:0] root [RootW+1];
  logic [SqW-1:0] bt [RootW+1];
  logic signed [2*SampleBits-1:0] ay2, az2;

  always_comb begin
    smp[0] = {s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32],
              s_axis_tdata[63:48], s_axis_tdata[79:64]};
    ay2    = smp[0].ay * smp[0].ay;
    az2    = smp[0].az * smp[0].az;
    rem[0] = ((SqW)'($unsigned(ay2)) + (SqW)'($unsigned(az2))) << (2 * Guard);
    root[0] = '0;
    bt[0]  = SqW'(1) << (2 * (RootW - 1));
  end

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    tha_sqrt_cell u_sq (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (rem[i]),
      .root_i(root[i]),
      .bit_i (bt[i]),
      .smp_i (smp[i]),
      .rem_o (rem[i+1]),
      .root_o(root[i+1]),
      .bit_o (bt[i+1]),
      .smp_o (smp[i+1])
    );
  end

  // Three CORDIC lanes fed from the end of the root chain.
  smp_t  s;
  cval_t py, px, ry, rx, yy, yx;
  logic signed [15:0] pitch_c, roll_c, yaw_c;
  logic [CordicStages:0] cen;

  assign s   = smp[RootW];
  assign py  = -(cval_t'(s.ax) <<< Guard);
  assign px  = cval_t'(root[RootW]);
  assign ry  = cval_t'(s.ay) <<< Guard;
  assign rx  = cval_t'(s.az) <<< Guard;
  assign yy  = cval_t'(s.my) <<< Guard;
  assign yx  = cval_t'(s.mx) <<< Guard;
  assign cen = {(CordicStages+1){adv}};

  tha_cordic_chain u_pitch (.clk_i(clk_i), .en_i(cen), .y_i(py), .x_i(px), .cdeg_o(pitch_c));
  tha_cordic_chain u_roll  (.clk_i(clk_i), .en_i(cen), .y_i(ry), .x_i(rx), .cdeg_o(roll_c));
  tha_cordic_chain u_yaw   (.clk_i(clk_i), .en_i(cen), .y_i(yy), .x_i(yx), .cdeg_o(yaw_c));

  // Final folding, wrapping and clamping.
  logic signed [16:0] pitch_f, roll_f, yaw_f;
  always_comb begin
    pitch_f = 17'(pitch_c);
    if (pitch_f > 17'sd9000) pitch_f = 17'sd9000;
    if (pitch_f < -17'sd9000) pitch_f = -17'sd9000;
    if (roll_c < 0) roll_f = -17'(roll_c) - 17'sd18000;
    else if (roll_c > 0) roll_f = 17'sd18000 - 17'(roll_c);
    else roll_f = '0;
    yaw_f = 17'(yaw_c);
    if (yaw_f < 0) yaw_f = yaw_f + 17'sd36000;
    if (yaw_f >= 17'sd36000) yaw_f = yaw_f - 17'sd36000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ld) begin
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) out_q <= {roll_f[15:0], pitch_f[14:0], yaw_f[15:0]};
  end

  // A held result must stay put while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_vld_q && vld_q[Depth-1])
    else $error("input stalled without a full chain end");
  a_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] < 16'd36000)
    else $error("yaw out of range");

endmodule
